// ===== rtl/grt_pkg.sv =====
// Shared types and constants for the grid ray traversal block.
package grt_pkg;

   localparam int COORD_W = 8;    // cell write coordinates
   localparam int POS_W   = 24;   // Q16.8 positions
   localparam int DIR_W   = 16;   // Q8.8 direction
   localparam int CSR_W   = 9;    // map size registers
   localparam int CSR_IDX_W = 1;
   localparam int T_W     = 32;   // Q16.16 ray parameter
   localparam int NUM_W   = 33;   // divider dividend (dist << 16 fits)

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CAST  = 1'b1;

   localparam logic [CSR_W-1:0] MAP_SIZE_RESET = 9'd256;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_MOD,
      ST_LOAD,
      ST_DIV,
      ST_STORE,
      ST_LOOKUP,
      ST_CHECK,
      ST_MUL_X,
      ST_MUL_Y,
      ST_FINISH
   } grt_state_type;

   typedef enum logic [1:0] {
      OP_TMAX_X,
      OP_TDELTA_X,
      OP_TMAX_Y,
      OP_TDELTA_Y
   } grt_op_type;

endpackage

// ===== rtl/grt_req_if.sv =====
// Request channel: cell writes and ray casts.
interface grt_req_if import grt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [COORD_W-1:0]        cell_x;
   logic [COORD_W-1:0]        cell_y;
   logic                      cell_solid;
   logic signed [POS_W-1:0]   start_x;
   logic signed [POS_W-1:0]   start_y;
   logic signed [DIR_W-1:0]   dir_x;
   logic signed [DIR_W-1:0]   dir_y;

   modport source (output valid, func, cell_x, cell_y, cell_solid,
                   start_x, start_y, dir_x, dir_y, input ready);
   modport sink   (input valid, func, cell_x, cell_y, cell_solid,
                   start_x, start_y, dir_x, dir_y, output ready);
endinterface

// ===== rtl/grt_rsp_if.sv =====
// Response channel: cast end point and hit flag.
interface grt_rsp_if import grt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   end_x;
   logic signed [POS_W-1:0]   end_y;
   logic                      hit_solid;

   modport source (output valid, end_x, end_y, hit_solid, input ready);
   modport sink   (input valid, end_x, end_y, hit_solid, output ready);
endinterface

// ===== rtl/grid_ray_traversal.sv =====
// Grid ray traversal over a one-bit solid tile map (top level).
//
//   channel   dir  handshake      carries
//   req_chan  in   valid/ready    func, cell write fields, ray start and direction
//   rsp_chan  out  valid/ready    end_x, end_y, hit_solid (one per cast request)
//   csr_*     in   csr_we         map_width (index 0), map_height (index 1)
//
// After reset the map memory is swept clear, one cell a cycle, over all
// MAX_MAP_WIDTH*MAX_MAP_HEIGHT cells; req_chan.ready stays low meanwhile.
// A write request updates the map, if its cell lies in the store, as it is
// accepted. A cast request runs start cell setup (reciprocal multiply in ST_CELL,
// then remainder in ST_MOD), four passes of a shared radix-2 divider (load, one
// step per dividend bit, store), a memory read and a check per visited cell, one
// more lookup when the ray leaves the map, then t*dir (ST_MUL_X, ST_MUL_Y) and the
// output register. A finished response waits in the output register; new
// requests are taken meanwhile, and a later cast stalls only in ST_FINISH until
// the earlier one is taken.
module grid_ray_traversal import grt_pkg::*; #(
   parameter int TILE_PIXELS    = 32,
   parameter int MAX_MAP_WIDTH  = 256,
   parameter int MAX_MAP_HEIGHT = 256
) (
   input  logic         clock,
   input  logic         reset,
   grt_req_if.sink      req_chan,
   grt_rsp_if.source    rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int TILE_RAW  = TILE_PIXELS * 256;
   localparam int TR_W      = $clog2(TILE_RAW + 1);
   localparam int DEN_W     = (TR_W > DIR_W) ? TR_W : DIR_W;
   localparam int MAP_CELLS = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
   localparam int ADDR_W    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
   localparam int MAX_DIM   = (MAX_MAP_WIDTH > MAX_MAP_HEIGHT) ? MAX_MAP_WIDTH
                                                               : MAX_MAP_HEIGHT;
   // cell index from the start position, or inside the map, plus one step
   localparam int SPOS_W    = POS_W - $clog2(TILE_RAW) + 3;
   localparam int SMAP_W    = $clog2(MAX_DIM + 1) + 2;
   localparam int CELL_W    = (SPOS_W > SMAP_W) ? SPOS_W : SMAP_W;
   localparam int WE_W      = ($clog2(MAX_DIM + 1) > CSR_W) ? $clog2(MAX_DIM + 1) : CSR_W;
   localparam int CMP_W     = (CELL_W > WE_W) ? CELL_W : WE_W;
   localparam int DCNT_W    = $clog2(NUM_W);
   localparam int PROD_W    = T_W + 1 + DIR_W;
   localparam int SUM_W     = PROD_W - 16 + 1;
   // start cell: floor(|pos| / 256 / TILE_PIXELS) by reciprocal multiply,
   // exact for |pos| / 256 up to 2^15 and TILE_PIXELS up to 256
   localparam int A_W       = POS_W - 8;
   localparam int RECIP_SH  = 24;
   localparam int RECIP     = ((1 << RECIP_SH) + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam int QP_W      = A_W + RECIP_SH;

   // ---------------- state and registers ----------------
   grt_state_type state_ff, state_in;
   grt_op_type    op_ff, op_next;

   logic [CSR_W-1:0] map_width_ff, map_height_ff;

   logic                     solid_mem [MAP_CELLS];
   logic                     rd_data_ff;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_wa;
   logic                     mem_wd;
   logic [ADDR_W-1:0]        clr_cnt_ff;

   logic signed [POS_W-1:0]  sx_ff, sy_ff;
   logic signed [DIR_W-1:0]  dx_ff, dy_ff;
   logic [WE_W-1:0]          w_eff_ff, h_eff_ff;

   logic [A_W-1:0]           qx_ff, qy_ff;

   logic [NUM_W-1:0]         quo_ff;
   logic [DEN_W-1:0]         rem_ff, den_ff;
   logic [DCNT_W-1:0]        div_cnt_ff;

   logic signed [CELL_W-1:0] x_ff, y_ff;
   logic [TR_W-1:0]          mx_ff, my_ff;
   logic [T_W-1:0]           tmx_ff, tmy_ff, tdx_ff, tdy_ff, t_ff;
   logic                     hit_ff;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [POS_W-1:0]  end_x_ff;

   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  rsp_end_x_ff, rsp_end_y_ff;
   logic                     rsp_hit_ff;

   // ---------------- combinational helpers ----------------
   logic                     req_take, rsp_load;
   logic [POS_W-1:0]         abs_sx, abs_sy;
   logic [DIR_W-1:0]         adx, ady;
   logic [TR_W-1:0]          dist_x, dist_y;
   logic [NUM_W-1:0]         num_sel;
   logic [DEN_W-1:0]         den_sel;
   logic [DEN_W:0]           trial;
   logic                     trial_ge;
   logic [QP_W-1:0]          qx_prod, qy_prod;
   logic [POS_W-1:0]         rem_x, rem_y;
   logic signed [CELL_W-1:0] qx_s, qy_s, x_start, y_start;
   logic [TR_W-1:0]          mx_start, my_start;
   logic [T_W-1:0]           t_quo;
   logic                     fx, fy, step_x, in_map;
   logic [ADDR_W-1:0]        cur_addr;
   logic [T_W:0]             tmx_sum, tmy_sum;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [POS_W-1:0]  end_sat;

   assign req_take = req_chan.valid && req_chan.ready;

   assign abs_sx = sx_ff[POS_W-1] ? POS_W'(-sx_ff) : POS_W'(sx_ff);
   assign abs_sy = sy_ff[POS_W-1] ? POS_W'(-sy_ff) : POS_W'(sy_ff);
   assign adx    = dx_ff[DIR_W-1] ? DIR_W'(-dx_ff) : DIR_W'(dx_ff);
   assign ady    = dy_ff[DIR_W-1] ? DIR_W'(-dy_ff) : DIR_W'(dy_ff);

   assign fx = (dx_ff != '0);
   assign fy = (dy_ff != '0);

   // start cell magnitude, registered in ST_CELL
   assign qx_prod = QP_W'(abs_sx[POS_W-1:8]) * QP_W'(RECIP);
   assign qy_prod = QP_W'(abs_sy[POS_W-1:8]) * QP_W'(RECIP);

   // floor cell and offset inside the cell, registered in ST_MOD
   assign rem_x    = abs_sx - POS_W'(POS_W'(qx_ff) * POS_W'(TILE_RAW));
   assign rem_y    = abs_sy - POS_W'(POS_W'(qy_ff) * POS_W'(TILE_RAW));
   assign qx_s     = $signed(CELL_W'(qx_ff));
   assign qy_s     = $signed(CELL_W'(qy_ff));
   assign x_start  = !sx_ff[POS_W-1] ? qx_s
                                     : ((rem_x != '0) ? -qx_s - CELL_W'(1) : -qx_s);
   assign y_start  = !sy_ff[POS_W-1] ? qy_s
                                     : ((rem_y != '0) ? -qy_s - CELL_W'(1) : -qy_s);
   assign mx_start = !sx_ff[POS_W-1] ? TR_W'(rem_x)
                     : ((rem_x != '0) ? TR_W'(TILE_RAW) - TR_W'(rem_x) : '0);
   assign my_start = !sy_ff[POS_W-1] ? TR_W'(rem_y)
                     : ((rem_y != '0) ? TR_W'(TILE_RAW) - TR_W'(rem_y) : '0);

   // distance to the next boundary in the step direction
   assign dist_x = (fx && !dx_ff[DIR_W-1]) ? TR_W'(TILE_RAW) - mx_ff : mx_ff;
   assign dist_y = (fy && !dy_ff[DIR_W-1]) ? TR_W'(TILE_RAW) - my_ff : my_ff;

   always_comb begin
      num_sel = '0;
      den_sel = '0;
      op_next = OP_TMAX_X;
      case (op_ff)
         OP_TMAX_X: begin
            num_sel = NUM_W'({dist_x, 16'h0000});
            den_sel = DEN_W'(adx);
            op_next = OP_TDELTA_X;
         end
         OP_TDELTA_X: begin
            num_sel = NUM_W'(TILE_RAW) << 16;
            den_sel = DEN_W'(adx);
            op_next = OP_TMAX_Y;
         end
         OP_TMAX_Y: begin
            num_sel = NUM_W'({dist_y, 16'h0000});
            den_sel = DEN_W'(ady);
            op_next = OP_TDELTA_Y;
         end
         OP_TDELTA_Y: begin
            num_sel = NUM_W'(TILE_RAW) << 16;
            den_sel = DEN_W'(ady);
            op_next = OP_TMAX_X;
         end
         default: begin
            num_sel = '0;
         end
      endcase
   end

   // restoring divider step
   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   assign t_quo    = (quo_ff[NUM_W-1:T_W] != '0) ? '1 : quo_ff[T_W-1:0];

   // traversal
   assign in_map = !x_ff[CELL_W-1] && !y_ff[CELL_W-1] &&
                   (CMP_W'(x_ff[CELL_W-2:0]) < CMP_W'(w_eff_ff)) &&
                   (CMP_W'(y_ff[CELL_W-2:0]) < CMP_W'(h_eff_ff));
   assign cur_addr = ADDR_W'(ADDR_W'(y_ff[CELL_W-2:0]) * ADDR_W'(MAX_MAP_WIDTH)
                             + ADDR_W'(x_ff[CELL_W-2:0]));
   assign step_x  = fx && (!fy || (tmx_ff < tmy_ff));
   assign tmx_sum = {1'b0, tmx_ff} + {1'b0, tdx_ff};
   assign tmy_sum = {1'b0, tmy_ff} + {1'b0, tdy_ff};

   // end point: start + floor(t*dir / 2^16), saturated
   assign prod_in = $signed({1'b0, t_ff}) *
                    ((state_ff == ST_MUL_X) ? dx_ff : dy_ff);

   function automatic logic signed [POS_W-1:0] sat_end(
      input logic signed [POS_W-1:0]  start,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [SUM_W-1:0] e;
      e = SUM_W'(start) + SUM_W'($signed(prod[PROD_W-1:16]));
      if (e > SUM_W'(8388607))
         return 24'sh7FFFFF;
      else if (e < -SUM_W'(8388608))
         return 24'sh800000;
      else
         return POS_W'(e);
   endfunction

   assign end_sat = sat_end((state_ff == ST_MUL_Y) ? sx_ff : sy_ff, prod_ff);

   // ---------------- state machine ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      mem_we         = 1'b0;
      mem_wa         = clr_cnt_ff;
      mem_wd         = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_cnt_ff == ADDR_W'(MAP_CELLS - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.func == FUNC_CAST) begin
                  state_in = ST_CELL;
               end else if ((32'(req_chan.cell_x) < MAX_MAP_WIDTH) &&
                            (32'(req_chan.cell_y) < MAX_MAP_HEIGHT)) begin
                  mem_we = 1'b1;
                  mem_wa = ADDR_W'(ADDR_W'(req_chan.cell_y) * ADDR_W'(MAX_MAP_WIDTH)
                                   + ADDR_W'(req_chan.cell_x));
                  mem_wd = req_chan.cell_solid;
               end
            end
         end
         ST_CELL:  state_in = ST_MOD;
         ST_MOD:   state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DCNT_W'(NUM_W - 1))
               state_in = ST_STORE;
         end
         ST_STORE: begin
            state_in = (op_ff == OP_TDELTA_Y) ? ST_LOOKUP : ST_LOAD;
         end
         ST_LOOKUP: begin
            state_in = in_map ? ST_CHECK : ST_MUL_X;
         end
         ST_CHECK: begin
            if (rd_data_ff || (!fx && !fy))
               state_in = ST_MUL_X;
            else
               state_in = ST_LOOKUP;
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- map memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we)
         solid_mem[mem_wa] <= mem_wd;
      rd_data_ff <= solid_mem[cur_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)
         clr_cnt_ff <= '0;
      else if (state_ff == ST_CLEAR)
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
   end

   // ---------------- config registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sx_ff  <= req_chan.start_x;
            sy_ff  <= req_chan.start_y;
            dx_ff  <= req_chan.dir_x;
            dy_ff  <= req_chan.dir_y;
            op_ff  <= OP_TMAX_X;
            t_ff   <= '0;
            hit_ff <= 1'b0;
            w_eff_ff <= (32'(map_width_ff) > MAX_MAP_WIDTH) ? WE_W'(MAX_MAP_WIDTH)
                                                          : WE_W'(map_width_ff);
            h_eff_ff <= (32'(map_height_ff) > MAX_MAP_HEIGHT) ? WE_W'(MAX_MAP_HEIGHT)
                                                            : WE_W'(map_height_ff);
         end
         ST_CELL: begin
            qx_ff <= qx_prod[QP_W-1:RECIP_SH];
            qy_ff <= qy_prod[QP_W-1:RECIP_SH];
         end
         ST_MOD: begin
            x_ff  <= x_start;
            mx_ff <= mx_start;
            y_ff  <= y_start;
            my_ff <= my_start;
         end
         ST_LOAD: begin
            quo_ff     <= num_sel;
            den_ff     <= den_sel;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
            quo_ff     <= {quo_ff[NUM_W-2:0], trial_ge};
            rem_ff     <= trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         end
         ST_STORE: begin
            op_ff <= op_next;
            case (op_ff)
               OP_TMAX_X:   tmx_ff <= t_quo;
               OP_TDELTA_X: tdx_ff <= t_quo;
               OP_TMAX_Y:   tmy_ff <= t_quo;
               OP_TDELTA_Y: tdy_ff <= t_quo;
               default: ;
            endcase
         end
         ST_CHECK: begin
            if (rd_data_ff) begin
               hit_ff <= 1'b1;
            end else if (step_x) begin
               t_ff   <= tmx_ff;
               tmx_ff <= tmx_sum[T_W] ? '1 : tmx_sum[T_W-1:0];
               x_ff   <= dx_ff[DIR_W-1] ? x_ff - CELL_W'(1) : x_ff + CELL_W'(1);
            end else if (fy) begin
               t_ff   <= tmy_ff;
               tmy_ff <= tmy_sum[T_W] ? '1 : tmy_sum[T_W-1:0];
               y_ff   <= dy_ff[DIR_W-1] ? y_ff - CELL_W'(1) : y_ff + CELL_W'(1);
            end
         end
         ST_MUL_X: prod_ff <= prod_in;
         ST_MUL_Y: begin
            end_x_ff <= end_sat;
            prod_ff  <= prod_in;
         end
         default: ;
      endcase
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_end_x_ff <= end_x_ff;
         rsp_end_y_ff <= end_sat;
         rsp_hit_ff   <= hit_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.end_x     = rsp_end_x_ff;
   assign rsp_chan.end_y     = rsp_end_y_ff;
   assign rsp_chan.hit_solid = rsp_hit_ff;

endmodule

// ===== verif/grid_ray_traversal_test.sv =====
// Self-checking regression for the grid ray traversal block.
`timescale 1ns / 100ps

module grid_ray_traversal_test;
   import grt_pkg::*;

   localparam int  TILE_PIX   = 32;
   localparam int  MAP_MAX    = 256;
   localparam int  TILE_SHIFT = 13;           // log2(TILE_PIX * 256)
   localparam longint TILE_RAW = 64'd8192;
   localparam longint T_MAX    = 64'h0000_0000_FFFF_FFFF;
   localparam int  IDLE_LIMIT = 300000;       // covers the clearing sweep after reset
   localparam int  DRAIN_PAD  = 20;

   typedef struct {
      logic                    func;
      logic [COORD_W-1:0]      cell_x;
      logic [COORD_W-1:0]      cell_y;
      logic                    cell_solid;
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
   } tile_req_type;

   typedef struct {
      logic signed [POS_W-1:0] end_x;
      logic signed [POS_W-1:0] end_y;
      logic                    hit_solid;
   } ray_end_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   grt_req_if req_bus ();
   grt_rsp_if rsp_bus ();

   grid_ray_traversal #(
      .TILE_PIXELS   (TILE_PIX),
      .MAX_MAP_WIDTH (MAP_MAX),
      .MAX_MAP_HEIGHT(MAP_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------
   // Predictor state: shadow of the solid map and the size registers
   // ---------------------------------------------------------------
   bit        solid_cells [MAP_MAX*MAP_MAX];
   int        map_w_reg;
   int        map_h_reg;

   tile_req_type request_queue[$];
   ray_end_type  expected_ends[$];

   int  max_gap;          // 0 gives back-to-back stretches
   int  error_count;
   int  request_count;
   int  cast_checked;
   int  phase_count;

   function automatic longint clamp_t(longint v);
      return (v > T_MAX) ? T_MAX : v;
   endfunction

   // Distance to the first boundary and per-cell distance on one axis.
   // Returns 0 for a zero component (never stepped).
   function automatic bit axis_setup(longint pos, longint v,
                                     output longint tmax, output longint tdelta);
      longint av, m, span;
      tmax = 0;
      tdelta = 0;
      if (v == 0) return 1'b0;
      av = (v < 0) ? -v : v;
      m = pos & (TILE_RAW - 1);
      span = (v > 0) ? TILE_RAW - m : m;
      tmax = clamp_t((span << 16) / av);
      tdelta = clamp_t((TILE_RAW << 16) / av);
      return 1'b1;
   endfunction

   // start + t*v, t*v floored to Q16.8, saturated to the port width
   function automatic logic signed [POS_W-1:0] ray_point(longint start, longint t,
                                                        longint v);
      longint p, off, e;
      p = t * v;
      if (p >= 0) off = p >>> 16;
      else off = -((-p + 65535) >>> 16);
      e = start + off;
      if (e > 64'sd8388607) e = 64'sd8388607;
      if (e < -64'sd8388608) e = -64'sd8388608;
      return e[POS_W-1:0];
   endfunction

   // Applies one accepted request; returns 1 when it produces a response.
   function automatic bit trace_ray(tile_req_type r, output ray_end_type res);
      longint sx, sy, dx, dy, x, y, w, h, tmx, tmy, tdx, tdy, t;
      bit fx, fy, hit;
      res = '{default: '0};
      if (r.func == FUNC_WRITE) begin
         solid_cells[int'(r.cell_y) * MAP_MAX + int'(r.cell_x)] = r.cell_solid;
         return 1'b0;
      end
      sx = longint'(r.start_x);
      sy = longint'(r.start_y);
      dx = longint'(r.dir_x);
      dy = longint'(r.dir_y);
      w = longint'((map_w_reg > MAP_MAX) ? MAP_MAX : map_w_reg);
      h = longint'((map_h_reg > MAP_MAX) ? MAP_MAX : map_h_reg);
      x = sx >>> TILE_SHIFT;
      y = sy >>> TILE_SHIFT;
      fx = axis_setup(sx, dx, tmx, tdx);
      fy = axis_setup(sy, dy, tmy, tdy);
      t = 0;
      hit = 1'b0;
      while (x >= 0 && x < w && y >= 0 && y < h) begin
         if (solid_cells[y * MAP_MAX + x]) begin
            hit = 1'b1;
            break;
         end
         if (!fx && !fy) break;
         // ties step the y axis
         if (fx && (!fy || tmx < tmy)) begin
            t = tmx;
            tmx = clamp_t(tmx + tdx);
            x += (dx > 0) ? 1 : -1;
         end else begin
            t = tmy;
            tmy = clamp_t(tmy + tdy);
            y += (dy > 0) ? 1 : -1;
         end
      end
      res.end_x = ray_point(sx, t, dx);
      res.end_y = ray_point(sy, t, dy);
      res.hit_solid = hit;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: pops pending requests, random gap after each
   // ---------------------------------------------------------------
   tile_req_type cur_req;
   int           req_gap;

   always @(posedge clock) begin
      ray_end_type res;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            request_count++;
            if (trace_ray(cur_req, res)) expected_ends.push_back(res);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               cur_req = request_queue.pop_front();
               req_bus.func       <= cur_req.func;
               req_bus.cell_x     <= cur_req.cell_x;
               req_bus.cell_y     <= cur_req.cell_y;
               req_bus.cell_solid <= cur_req.cell_solid;
               req_bus.start_x    <= cur_req.start_x;
               req_bus.start_y    <= cur_req.start_y;
               req_bus.dir_x      <= cur_req.dir_x;
               req_bus.dir_y      <= cur_req.dir_y;
               req_bus.valid      <= 1'b1;
               req_gap = $urandom_range(0, max_gap);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: random stall after each response, in-order check
   // ---------------------------------------------------------------
   int rsp_stall;

   always @(posedge clock) begin
      ray_end_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ends.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: response with nothing expected: end=(%0d,%0d) hit=%0b",
                           rsp_bus.end_x, rsp_bus.end_y, rsp_bus.hit_solid);
            end else begin
               want = expected_ends.pop_front();
               cast_checked++;
               if (rsp_bus.end_x !== want.end_x || rsp_bus.end_y !== want.end_y ||
                   rsp_bus.hit_solid !== want.hit_solid) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: cast %0d: expected (%0d,%0d) hit=%0b, got (%0d,%0d) hit=%0b",
                              cast_checked, want.end_x, want.end_y, want.hit_solid,
                              rsp_bus.end_x, rsp_bus.end_y, rsp_bus.hit_solid);
               end
            end
            rsp_stall = $urandom_range(0, max_gap);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: stops the whole run, as a failure, when idle_cycles with no handshake on either side reach IDLE_LIMIT
   int idle_cycles;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("grid_ray_traversal regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_write(int cx, int cy, bit solid);
      tile_req_type r;
      r = '{default: '0};
      r.func = FUNC_WRITE;
      r.cell_x = cx[COORD_W-1:0];
      r.cell_y = cy[COORD_W-1:0];
      r.cell_solid = solid;
      // junk in the cast fields, the block must ignore it
      r.start_x = POS_W'($urandom());
      r.start_y = POS_W'($urandom());
      r.dir_x = DIR_W'($urandom());
      r.dir_y = DIR_W'($urandom());
      request_queue.push_back(r);
   endtask

   task automatic push_cast(int sx, int sy, int dx, int dy);
      tile_req_type r;
      r = '{default: '0};
      r.func = FUNC_CAST;
      r.cell_x = COORD_W'($urandom());
      r.cell_y = COORD_W'($urandom());
      r.cell_solid = 1'($urandom());
      r.start_x = sx[POS_W-1:0];
      r.start_y = sy[POS_W-1:0];
      r.dir_x = dx[DIR_W-1:0];
      r.dir_y = dy[DIR_W-1:0];
      request_queue.push_back(r);
   endtask

   // Map registers change only with the block idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MAP_WIDTH) map_w_reg = value;
      else map_h_reg = value;
   endtask

   task automatic drain();
      while (request_queue.size() > 0 || req_bus.valid || expected_ends.size() > 0)
         @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   function automatic int rand_dir();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 0;
      if (sel == 1) return 25600;
      if (sel == 2) return -25600;
      if (sel == 3) return $urandom_range(0, 64) - 32;    // very slow rays
      return $urandom_range(0, 51200) - 25600;
   endfunction

   function automatic int rand_coord(int cells);
      int off;
      off = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 8191);
      return $urandom_range(0, cells - 1) * 8192 + off;
   endfunction

   // One phase of mixed writes and casts for the current map size.
   task automatic run_phase(int n_items);
      int ew, eh, density;
      ew = (map_w_reg > MAP_MAX) ? MAP_MAX : map_w_reg;
      eh = (map_h_reg > MAP_MAX) ? MAP_MAX : map_h_reg;
      density = $urandom_range(5, 60);
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 99) < 40) begin
            if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 7)
               push_write($urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                          $urandom_range(0, 99) < density);
            else
               push_write($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 99) < density);
         end else if (ew > 0 && eh > 0 && $urandom_range(0, 99) < 85) begin
            push_cast(rand_coord(ew), rand_coord(eh), rand_dir(), rand_dir());
         end else begin
            // noise: anywhere in the 24-bit space, any legal direction
            push_cast($urandom(), $urandom(), rand_dir(), rand_dir());
         end
      end
      drain();
      phase_count++;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int w, h;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_WRITE;
      req_bus.cell_x = '0;
      req_bus.cell_y = '0;
      req_bus.cell_solid = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      rsp_bus.ready = 1'b0;
      map_w_reg = int'(MAP_SIZE_RESET);
      map_h_reg = int'(MAP_SIZE_RESET);
      max_gap = 11;
      error_count = 0;
      request_count = 0;
      cast_checked = 0;
      phase_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset map size (256 x 256, empty map).
      push_cast(100 * 256 + 128, 70 * 256, 0, 0);              // zero direction
      push_cast(-8388608, -8388608, 25600, 25600);             // start off map, low
      push_cast(8388607, 8388607, -25600, -25600);             // start off map, high
      push_cast(3 * 8192 + 4096, 2 * 8192 + 4096, 25600, -25600); // diagonal, leaves
      push_write(0, 0, 1'b1);
      push_write(255, 255, 1'b1);
      push_write(255, 0, 1'b1);
      push_cast(100, 200, -25600, 0);                          // starts on solid cell
      push_cast(3 * 8192 + 4096, 3 * 8192 + 4096, -256, -256); // equal axes: y first
      push_cast(10 * 8192 + 100, 255 * 8192 + 5, 25600, 0);    // runs into far corner
      push_cast(5 * 8192, 7 * 8192, 0, -1);                    // on boundary, slowest neg
      push_cast(5 * 8192, 7 * 8192, 1, 0);                     // on boundary, slowest pos
      push_cast(200 * 8192, 9 * 8192 + 77, 25600, -25600);
      push_write(0, 0, 1'b0);                                  // clear again
      push_cast(10, 10, 0, 0);
      push_cast(2 * 8192 + 1, 8191, -25600, -1);
      push_cast(8388607, 0, -1, 25600);
      drain();
      phase_count++;

      // Extremes of the size registers, then mostly small maps.
      write_csr(CSR_MAP_WIDTH, 0);
      write_csr(CSR_MAP_HEIGHT, 5);
      run_phase(40);
      write_csr(CSR_MAP_WIDTH, 1);
      write_csr(CSR_MAP_HEIGHT, 1);
      run_phase(60);
      write_csr(CSR_MAP_WIDTH, 511);                           // above store size
      write_csr(CSR_MAP_HEIGHT, 300);
      run_phase(40);
      write_csr(CSR_MAP_WIDTH, 256);
      write_csr(CSR_MAP_HEIGHT, 0);
      run_phase(30);
      write_csr(CSR_MAP_WIDTH, 256);
      write_csr(CSR_MAP_HEIGHT, 2);
      run_phase(60);
      for (int p = 0; p < 12; p++) begin
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 24);
         write_csr(CSR_MAP_WIDTH, w);
         write_csr(CSR_MAP_HEIGHT, h);
         run_phase(70);
      end

      $display("covered %0d requests, %0d casts checked over %0d phases of map size",
               request_count, cast_checked, phase_count);
      if (error_count == 0) begin
         $display("grid_ray_traversal regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("grid_ray_traversal regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/grt_pkg.sv
rtl/grt_req_if.sv
rtl/grt_rsp_if.sv
rtl/grid_ray_traversal.sv
verif/grid_ray_traversal_test.sv
